[hw/rtl/csfw_pkg.sv]
package csfw_pkg;

  // Request types
  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_TRY     = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_CANCEL  = 2'd3
  } req_type_e;

  // Result event kinds
  typedef enum logic [3:0] {
    EV_GRANTED     = 4'd0,
    EV_QUEUED      = 4'd1,
    EV_REFUSED     = 4'd2,
    EV_WOKEN       = 4'd3,
    EV_INTERRUPTED = 4'd4,
    EV_RELEASED    = 4'd5,
    EV_OVER_MAX    = 4'd6,
    EV_QUEUE_FULL  = 4'd7,
    EV_NOT_FOUND   = 4'd8
  } ev_kind_e;

  // Shared adder operations
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT     = 2'd1;

  localparam logic [CFG_DATA_W-1:0] INITIAL_COUNT_RST = 16'd1;
  localparam logic [CFG_DATA_W-1:0] MAX_COUNT_RST     = 16'hFFFF;

  localparam int TAG_W     = 8;
  localparam int REQ_CNT_W = 16;
  localparam int AVAIL_W   = 16;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [TAG_W-1:0]     req_tag;
    logic [REQ_CNT_W-1:0] req_count;
    logic                 already_cancelled;
  } req_t;

  typedef struct packed {
    logic [3:0]         event_kind;
    logic [TAG_W-1:0]   event_tag;
    logic [AVAIL_W-1:0] available;
    logic               last;
  } evt_t;

  // Waiter queue commands
  typedef struct packed {
    logic rd;      // registered read of a logical entry
    logic wr;      // write of a logical entry
    logic grow;    // append: length + 1
    logic pop;     // drop head
    logic shrink;  // drop tail after a compaction
  } qcmd_t;

endpackage

[hw/rtl/counting_semaphore_fifo_waiters_unit.sv]
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    csfw_pkg::req_t
// out       output     out_valid_o / out_stall_i  csfw_pkg::evt_t
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One request at a time: a sequencer around one shared adder and a ring-buffer queue.
// Acquire and try-acquire are decided directly. Release checks max_count, walks the waiters
// its units cover from the head, then pops and reports each woken waiter; over max stops there.
// Cancel searches for the oldest match, then moves every later entry up one place.
// Reset clears the queue length; the available count takes the initial_count reset value.
// Output stalls hold the sequencer only when a result is ready to leave.
module counting_semaphore_fifo_waiters_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  csfw_pkg::req_t                        in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output csfw_pkg::evt_t                        out_data_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [csfw_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [csfw_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int AW   = (COUNT_BITS > 16 ? COUNT_BITS : 16) + 1;
  localparam int IdxW = $clog2(QUEUE_DEPTH);
  localparam int LenW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [LenW-1:0] DepthL = LenW'(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_REL_CHK,
    S_P1_RD,
    S_P1_CHK,
    S_P2,
    S_P2_OUT,
    S_C_RD,
    S_C_CHK,
    S_C_SH_RD,
    S_C_SH_WR,
    S_EMIT
  } state_e;

  state_e               state_q;
  csfw_pkg::req_t       req_q;
  csfw_pkg::ev_kind_e   kind_q;
  logic [COUNT_BITS-1:0] avail_q;
  logic [csfw_pkg::CFG_DATA_W-1:0] max_q;
  logic [AW-1:0]        total_q;
  logic [LenW-1:0]      idx_q;
  logic [LenW-1:0]      nwake_q;
  logic                 out_valid_q;
  csfw_pkg::evt_t       out_data_q;

  logic [AW-1:0]         avail_ext, cnt_raw_ext, cnt_ext, max_ext, units_ext, cfg_ext;
  logic [COUNT_BITS-1:0] cnt_cb;
  logic [csfw_pkg::AVAIL_W-1:0] avail16;
  logic [LenW-1:0]       idx_inc;
  logic                  out_free;
  logic                  out_load;

  csfw_pkg::alu_op_e     alu_op;
  logic [AW-1:0]         alu_a, alu_b, alu_res;
  logic                  alu_ge;

  csfw_pkg::qcmd_t             qcmd;
  logic [IdxW-1:0]             q_rd_idx, q_wr_idx;
  logic [csfw_pkg::TAG_W-1:0]  q_wr_tag, q_rd_tag;
  logic [COUNT_BITS-1:0]       q_wr_units, q_rd_units;
  logic [LenW-1:0]             qlen;
  logic                        push_ok;

  // Operand views
  always_comb begin
    avail_ext   = AW'(avail_q);
    avail16     = avail_ext[csfw_pkg::AVAIL_W-1:0];
    cnt_raw_ext = AW'(req_q.req_count);
    cnt_cb      = cnt_raw_ext[COUNT_BITS-1:0];
    cnt_ext     = AW'(cnt_cb);
    max_ext     = AW'(max_q);
    units_ext   = AW'(q_rd_units);
    cfg_ext     = AW'(cfg_data_i);
    idx_inc     = idx_q + LenW'(1);
    out_free    = !out_valid_q || !out_stall_i;
    out_load    = out_free && ((state_q == S_P2_OUT) || (state_q == S_EMIT));
  end

  csfw_alu #(
    .Width (AW)
  ) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .op_i  (alu_op),
    .res_o (alu_res),
    .ge_o  (alu_ge)
  );

  csfw_queue #(
    .Depth (QUEUE_DEPTH),
    .UnitW (COUNT_BITS)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (qcmd),
    .rd_idx_i   (q_rd_idx),
    .wr_idx_i   (q_wr_idx),
    .wr_tag_i   (q_wr_tag),
    .wr_units_i (q_wr_units),
    .rd_tag_o   (q_rd_tag),
    .rd_units_o (q_rd_units),
    .len_o      (qlen)
  );

  // A blocking acquire that has to wait and still fits in the queue
  assign push_ok = (req_q.req_type == csfw_pkg::REQ_ACQUIRE) && !req_q.already_cancelled &&
                   !(alu_ge && qlen == '0) && (qlen != DepthL);

  // Adder operands and queue commands per step
  always_comb begin
    alu_op     = csfw_pkg::ALU_SUB;
    alu_a      = avail_ext;
    alu_b      = cnt_ext;
    qcmd       = '0;
    q_rd_idx   = idx_q[IdxW-1:0];
    q_wr_idx   = idx_q[IdxW-1:0];
    q_wr_tag   = req_q.req_tag;
    q_wr_units = cnt_cb;
    unique case (state_q)
      S_DECIDE: begin
        if (req_q.req_type == csfw_pkg::REQ_RELEASE) begin
          alu_op = csfw_pkg::ALU_ADD;
        end
        if (push_ok) begin
          qcmd.wr   = 1'b1;
          qcmd.grow = 1'b1;
          q_wr_idx  = qlen[IdxW-1:0];
        end
      end
      S_REL_CHK: begin
        alu_a = max_ext;
        alu_b = total_q;
      end
      S_P1_RD: begin
        qcmd.rd = (idx_q != qlen);
      end
      S_P1_CHK: begin
        alu_a = total_q;
        alu_b = units_ext;
      end
      S_P2: begin
        qcmd.rd  = (nwake_q != '0);
        q_rd_idx = '0;
      end
      S_P2_OUT: begin
        qcmd.pop = out_free;
      end
      S_C_RD: begin
        qcmd.rd = (idx_q != qlen);
      end
      S_C_SH_RD: begin
        q_rd_idx = idx_inc[IdxW-1:0];
        if (idx_inc < qlen) begin
          qcmd.rd = 1'b1;
        end else begin
          qcmd.shrink = 1'b1;
        end
      end
      S_C_SH_WR: begin
        qcmd.wr    = 1'b1;
        q_wr_tag   = q_rd_tag;
        q_wr_units = q_rd_units;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      kind_q      <= csfw_pkg::EV_GRANTED;
      avail_q     <= COUNT_BITS'(csfw_pkg::INITIAL_COUNT_RST);
      max_q       <= csfw_pkg::MAX_COUNT_RST;
      total_q     <= '0;
      idx_q       <= '0;
      nwake_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // register writes
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == csfw_pkg::CFG_INITIAL_COUNT) begin
          avail_q <= cfg_ext[COUNT_BITS-1:0];
        end
        if (cfg_index_i == csfw_pkg::CFG_MAX_COUNT) begin
          max_q <= cfg_data_i;
        end
      end

      // result register: load a new result or drop a transferred one
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_data_i;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          unique case (req_q.req_type)
            csfw_pkg::REQ_ACQUIRE: begin
              state_q <= S_EMIT;
              if (req_q.already_cancelled) begin
                kind_q <= csfw_pkg::EV_INTERRUPTED;
              end else if (alu_ge && qlen == '0) begin
                avail_q <= alu_res[COUNT_BITS-1:0];
                kind_q  <= csfw_pkg::EV_GRANTED;
              end else if (qlen == DepthL) begin
                kind_q <= csfw_pkg::EV_QUEUE_FULL;
              end else begin
                kind_q <= csfw_pkg::EV_QUEUED;
              end
            end
            csfw_pkg::REQ_TRY: begin
              state_q <= S_EMIT;
              if (alu_ge && qlen == '0) begin
                avail_q <= alu_res[COUNT_BITS-1:0];
                kind_q  <= csfw_pkg::EV_GRANTED;
              end else begin
                kind_q <= csfw_pkg::EV_REFUSED;
              end
            end
            csfw_pkg::REQ_RELEASE: begin
              total_q <= alu_res;
              state_q <= S_REL_CHK;
            end
            csfw_pkg::REQ_CANCEL: begin
              idx_q   <= '0;
              state_q <= S_C_RD;
            end
          endcase
        end
        // total must not pass max_count
        S_REL_CHK: begin
          if (alu_ge) begin
            idx_q   <= '0;
            state_q <= S_P1_RD;
          end else begin
            kind_q  <= csfw_pkg::EV_OVER_MAX;
            state_q <= S_EMIT;
          end
        end
        // first pass: count waiters the units cover, settle the final count
        S_P1_RD: begin
          if (idx_q == qlen) begin
            avail_q <= total_q[COUNT_BITS-1:0];
            nwake_q <= idx_q;
            state_q <= S_P2;
          end else begin
            state_q <= S_P1_CHK;
          end
        end
        S_P1_CHK: begin
          if (alu_ge) begin
            total_q <= alu_res;
            idx_q   <= idx_inc;
            state_q <= S_P1_RD;
          end else begin
            avail_q <= total_q[COUNT_BITS-1:0];
            nwake_q <= idx_q;
            state_q <= S_P2;
          end
        end
        // second pass: pop and report woken waiters
        S_P2: begin
          if (nwake_q == '0) begin
            kind_q  <= csfw_pkg::EV_RELEASED;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_P2_OUT;
          end
        end
        S_P2_OUT: begin
          if (out_free) begin
            out_data_q.event_kind <= csfw_pkg::EV_WOKEN;
            out_data_q.event_tag  <= q_rd_tag;
            out_data_q.available  <= avail16;
            out_data_q.last       <= 1'b0;
            nwake_q               <= nwake_q - LenW'(1);
            state_q               <= S_P2;
          end
        end
        // cancel: search oldest match
        S_C_RD: begin
          if (idx_q == qlen) begin
            kind_q  <= csfw_pkg::EV_NOT_FOUND;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_C_CHK;
          end
        end
        S_C_CHK: begin
          if (q_rd_tag == req_q.req_tag) begin
            state_q <= S_C_SH_RD;
          end else begin
            idx_q   <= idx_inc;
            state_q <= S_C_RD;
          end
        end
        // close the gap one entry at a time
        S_C_SH_RD: begin
          if (idx_inc < qlen) begin
            state_q <= S_C_SH_WR;
          end else begin
            kind_q  <= csfw_pkg::EV_INTERRUPTED;
            state_q <= S_EMIT;
          end
        end
        S_C_SH_WR: begin
          idx_q   <= idx_inc;
          state_q <= S_C_SH_RD;
        end
        S_EMIT: begin
          if (out_free) begin
            out_data_q.event_kind <= kind_q;
            out_data_q.event_tag  <= req_q.req_tag;
            out_data_q.available  <= avail16;
            out_data_q.last       <= 1'b1;
            state_q               <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  // register writes only between requests
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  a_qlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qlen <= DepthL)
    else $error("waiter queue length beyond depth");

  a_nonlast_is_woken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.last) |-> (out_data_o.event_kind == csfw_pkg::EV_WOKEN))
    else $error("non-final result that is not a wake-up");

  a_release_within_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_P2) |-> (avail_ext <= max_ext))
    else $error("count after release exceeds max_count");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcmd.pop |-> (qlen != '0))
    else $error("pop from empty waiter queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcmd.grow |-> (qlen < DepthL))
    else $error("push into full waiter queue");

endmodule

[hw/rtl/csfw_alu.sv]
module csfw_alu #(
  parameter int Width = 17
) (
  input  logic [Width-1:0]     a_i,
  input  logic [Width-1:0]     b_i,
  input  csfw_pkg::alu_op_e    op_i,
  output logic [Width-1:0]     res_o,
  output logic                 ge_o
);

  // One adder/subtractor plus magnitude compare, shared by all steps
  always_comb begin
    unique case (op_i)
      csfw_pkg::ALU_ADD: res_o = a_i + b_i;
      csfw_pkg::ALU_SUB: res_o = a_i - b_i;
      default:           res_o = a_i - b_i;
    endcase
  end

  assign ge_o = (a_i >= b_i);

endmodule

[hw/rtl/csfw_queue.sv]
module csfw_queue #(
  parameter int Depth = 16,
  parameter int UnitW = 16,
  localparam int IdxW = $clog2(Depth),
  localparam int LenW = $clog2(Depth + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  csfw_pkg::qcmd_t            cmd_i,
  input  logic [IdxW-1:0]            rd_idx_i,
  input  logic [IdxW-1:0]            wr_idx_i,
  input  logic [csfw_pkg::TAG_W-1:0] wr_tag_i,
  input  logic [UnitW-1:0]           wr_units_i,
  output logic [csfw_pkg::TAG_W-1:0] rd_tag_o,
  output logic [UnitW-1:0]           rd_units_o,
  output logic [LenW-1:0]            len_o
);

  localparam logic [IdxW:0]   DepthL = (IdxW + 1)'(Depth);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);

  logic [csfw_pkg::TAG_W-1:0] mem_tag_q   [Depth];
  logic [UnitW-1:0]           mem_units_q [Depth];

  logic [IdxW-1:0] head_q;
  logic [LenW-1:0] len_q;

  logic [IdxW:0]   rd_sum, rd_wrap, wr_sum, wr_wrap;
  logic [IdxW-1:0] rd_phys, wr_phys;

  // Logical index to ring position
  always_comb begin
    rd_sum  = {1'b0, head_q} + {1'b0, rd_idx_i};
    rd_wrap = rd_sum - DepthL;
    rd_phys = (rd_sum >= DepthL) ? rd_wrap[IdxW-1:0] : rd_sum[IdxW-1:0];
    wr_sum  = {1'b0, head_q} + {1'b0, wr_idx_i};
    wr_wrap = wr_sum - DepthL;
    wr_phys = (wr_sum >= DepthL) ? wr_wrap[IdxW-1:0] : wr_sum[IdxW-1:0];
  end

  // Storage write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_tag_q[wr_phys]   <= wr_tag_i;
      mem_units_q[wr_phys] <= wr_units_i;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_tag_o   <= mem_tag_q[rd_phys];
      rd_units_o <= mem_units_q[rd_phys];
    end
  end

  // Head pointer and fill length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      len_q  <= '0;
    end else begin
      if (cmd_i.grow) begin
        len_q <= len_q + LenW'(1);
      end else if (cmd_i.pop) begin
        head_q <= (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
        len_q  <= len_q - LenW'(1);
      end else if (cmd_i.shrink) begin
        len_q <= len_q - LenW'(1);
      end
    end
  end

  assign len_o = len_q;

endmodule

[tb/sv/counting_semaphore_fifo_waiters_unit_tb.sv]
`timescale 1ns / 1ps

module counting_semaphore_fifo_waiters_unit_tb;
  import csfw_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  localparam int COUNT_BITS     = 16;
  // longest quiet stretch: sender gap + full release walk + receiver stall, many times over
  localparam int WATCHDOG_LIMIT = 3000;
  // release walking and waking a full queue
  localparam int DRAIN_CYCLES   = 80;
  localparam int SETTLE_CYCLES  = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd2;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  req_t                  in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  evt_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Predicted semaphore state
  logic [AVAIL_W-1:0]   sem_avail;
  logic [AVAIL_W-1:0]   max_reg;
  logic [TAG_W-1:0]     waiter_tags[$];
  logic [REQ_CNT_W-1:0] waiter_units[$];
  evt_t                 expected_events[$];

  int   err_count  = 0;
  bit   idle_on    = 1'b1;
  int   stall_left = 0;
  evt_t got_evt;
  evt_t want_evt;

  wire any_xfer = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                  (cfg_valid && cfg_ready);

  counting_semaphore_fifo_waiters_unit #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COUNT_BITS  (COUNT_BITS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    else if (r < 95) return $urandom_range(4, 10);
    else return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic push_event(input ev_kind_e kind, input logic [TAG_W-1:0] tag,
                            input logic last_flag);
    evt_t e;
    e.event_kind = kind;
    e.event_tag  = tag;
    e.available  = sem_avail;
    e.last       = last_flag;
    expected_events.push_back(e);
  endtask

  // Semaphore behavior for one accepted request; state is updated before
  // results are queued so every result carries the final count
  task automatic predict_request(input req_t r);
    logic [TAG_W-1:0] woken[$];
    logic [AVAIL_W:0] total;
    int               hit;
    int               i;
    hit = -1;
    case (r.req_type)
      REQ_ACQUIRE: begin
        if (r.already_cancelled) begin
          push_event(EV_INTERRUPTED, r.req_tag, 1'b1);
        end else if (sem_avail >= r.req_count && waiter_tags.size() == 0) begin
          sem_avail = sem_avail - r.req_count;
          push_event(EV_GRANTED, r.req_tag, 1'b1);
        end else if (waiter_tags.size() >= QUEUE_DEPTH) begin
          push_event(EV_QUEUE_FULL, r.req_tag, 1'b1);
        end else begin
          waiter_tags.push_back(r.req_tag);
          waiter_units.push_back(r.req_count);
          push_event(EV_QUEUED, r.req_tag, 1'b1);
        end
      end
      REQ_TRY: begin
        if (sem_avail >= r.req_count && waiter_tags.size() == 0) begin
          sem_avail = sem_avail - r.req_count;
          push_event(EV_GRANTED, r.req_tag, 1'b1);
        end else begin
          push_event(EV_REFUSED, r.req_tag, 1'b1);
        end
      end
      REQ_RELEASE: begin
        if (sem_avail > max_reg || r.req_count > max_reg - sem_avail) begin
          push_event(EV_OVER_MAX, r.req_tag, 1'b1);
        end else begin
          total = sem_avail + r.req_count;
          // wake from the head while the units cover it
          while (waiter_units.size() > 0 && total >= waiter_units[0]) begin
            total = total - waiter_units[0];
            woken.push_back(waiter_tags[0]);
            waiter_tags.delete(0);
            waiter_units.delete(0);
          end
          sem_avail = total[AVAIL_W-1:0];
          foreach (woken[k]) push_event(EV_WOKEN, woken[k], 1'b0);
          push_event(EV_RELEASED, r.req_tag, 1'b1);
        end
      end
      default: begin
        // cancel drops the oldest matching waiter
        for (i = 0; i < waiter_tags.size(); i++) begin
          if (hit < 0 && waiter_tags[i] == r.req_tag) hit = i;
        end
        if (hit >= 0) begin
          waiter_tags.delete(hit);
          waiter_units.delete(hit);
          push_event(EV_INTERRUPTED, r.req_tag, 1'b1);
        end else begin
          push_event(EV_NOT_FOUND, r.req_tag, 1'b1);
        end
      end
    endcase
  endtask

  function automatic req_t make_req(input req_type_e kind, input logic [TAG_W-1:0] tag,
                                    input logic [REQ_CNT_W-1:0] count,
                                    input logic cancelled);
    req_t r;
    r.req_type          = kind;
    r.req_tag           = tag;
    r.req_count         = count;
    r.already_cancelled = cancelled;
    return r;
  endfunction

  // Mostly small counts and a small tag pool so waiters pile up and get cancelled
  function automatic req_t random_request(input int acquire_pct);
    req_t r;
    int   pick;
    int   sel;
    int   rest;
    r    = '0;
    rest = 100 - acquire_pct;
    pick = $urandom_range(0, 99);
    if (pick < acquire_pct) r.req_type = REQ_ACQUIRE;
    else if (pick < acquire_pct + rest / 4) r.req_type = REQ_TRY;
    else if (pick < acquire_pct + (rest * 3) / 4) r.req_type = REQ_RELEASE;
    else r.req_type = REQ_CANCEL;
    if ($urandom_range(0, 3) == 0) r.req_tag = TAG_W'($urandom);
    else r.req_tag = TAG_W'($urandom_range(0, 7));
    if (r.req_type == REQ_CANCEL && waiter_tags.size() != 0 && $urandom_range(0, 3) != 0)
      r.req_tag = waiter_tags[$urandom_range(0, waiter_tags.size() - 1)];
    sel = $urandom_range(0, 99);
    if (sel < 70) r.req_count = REQ_CNT_W'($urandom_range(0, 4));
    else if (sel < 80) r.req_count = REQ_CNT_W'($urandom);
    else if (sel < 90) r.req_count = (r.req_type == REQ_RELEASE) ? max_reg - sem_avail
                                                                  : sem_avail;
    else if (sel < 95) r.req_count = 16'hFFFF;
    else r.req_count = sem_avail + 16'd1;
    r.already_cancelled = ($urandom_range(0, 9) == 0);
    return r;
  endfunction

  // Lower valid, then wait for every predicted result to leave
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One request transfer; valid stays high for a back-to-back follower
  task automatic send_req(input req_t r);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!(in_valid && !in_stall));
    predict_request(r);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == CFG_INITIAL_COUNT) begin
      sem_avail = val;
    end else if (idx == CFG_MAX_COUNT) begin
      max_reg = val;
    end
    cfg_valid <= 1'b0;
  endtask

  // Result checker: oldest expectation against each result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_evt = out_data;
      if (expected_events.size() == 0) begin
        report_mismatch("result with none expected, kind", 32'(got_evt.event_kind), '0);
      end else begin
        want_evt = expected_events.pop_front();
        if (got_evt.event_kind !== want_evt.event_kind)
          report_mismatch("event_kind", 32'(got_evt.event_kind), 32'(want_evt.event_kind));
        if (got_evt.event_tag !== want_evt.event_tag)
          report_mismatch("event_tag", 32'(got_evt.event_tag), 32'(want_evt.event_tag));
        if (got_evt.available !== want_evt.available)
          report_mismatch("available", 32'(got_evt.available), 32'(want_evt.available));
        if (got_evt.last !== want_evt.last)
          report_mismatch("last", 32'(got_evt.last), 32'(want_evt.last));
      end
    end
  end

  // Receiver stalls in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (any_xfer) quiet = 0;
      else quiet++;
    end
    $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Every operation and every outcome but queue full at reset settings
  task automatic test_basic_ops();
    send_req(make_req(REQ_TRY,     8'h00, 16'd0,     1'b0));  // granted
    send_req(make_req(REQ_ACQUIRE, 8'hFF, 16'd1,     1'b0));  // granted, none left
    send_req(make_req(REQ_TRY,     8'h01, 16'd1,     1'b0));  // refused
    send_req(make_req(REQ_ACQUIRE, 8'h02, 16'd0,     1'b1));  // cancelled token
    send_req(make_req(REQ_TRY,     8'h03, 16'd0,     1'b1));  // token ignored
    send_req(make_req(REQ_ACQUIRE, 8'h11, 16'd2,     1'b0));  // queued
    send_req(make_req(REQ_ACQUIRE, 8'h22, 16'd0,     1'b0));  // zero count behind waiter
    send_req(make_req(REQ_ACQUIRE, 8'h11, 16'd1,     1'b0));  // duplicate tag
    send_req(make_req(REQ_TRY,     8'h44, 16'd0,     1'b0));  // refused, waiters present
    send_req(make_req(REQ_CANCEL,  8'h11, 16'd0,     1'b0));  // drops oldest 0x11
    send_req(make_req(REQ_CANCEL,  8'h99, 16'd0,     1'b0));  // unknown tag
    send_req(make_req(REQ_RELEASE, 8'h33, 16'd1,     1'b0));  // wakes two
    send_req(make_req(REQ_RELEASE, 8'h55, 16'hFFFF,  1'b0));  // exactly at max
    send_req(make_req(REQ_RELEASE, 8'h66, 16'd1,     1'b0));  // over max
    send_req(make_req(REQ_ACQUIRE, 8'h77, 16'hFFFF,  1'b0));  // takes everything
  endtask

  // Register extremes, count above max, reload with waiters queued
  task automatic test_config_limits();
    cfg_write(CFG_MAX_COUNT, 16'd1);
    cfg_write(CFG_INITIAL_COUNT, 16'd0);
    send_req(make_req(REQ_RELEASE, 8'h81, 16'd2, 1'b0));
    send_req(make_req(REQ_RELEASE, 8'h81, 16'd1, 1'b0));
    cfg_write(CFG_INITIAL_COUNT, 16'hFFFF);
    send_req(make_req(REQ_RELEASE, 8'h82, 16'd0, 1'b0));     // available above max
    send_req(make_req(REQ_ACQUIRE, 8'h83, 16'hFFFF, 1'b0));
    send_req(make_req(REQ_ACQUIRE, 8'hAA, 16'd1, 1'b0));
    cfg_write(CFG_INITIAL_COUNT, 16'd1);                    // waiter stays queued
    send_req(make_req(REQ_RELEASE, 8'h84, 16'd0, 1'b0));
  endtask

  // Fill the queue, overflow it, then wake every waiter in one release
  task automatic test_queue_full();
    int i;
    cfg_write(CFG_MAX_COUNT, 16'hFFFF);
    cfg_write(CFG_INITIAL_COUNT, 16'd0);
    for (i = 0; i < QUEUE_DEPTH; i++)
      send_req(make_req(REQ_ACQUIRE, 8'(i) ^ 8'hA5, 16'd1, 1'b0));
    send_req(make_req(REQ_ACQUIRE, 8'h5A, 16'd0, 1'b0));
    send_req(make_req(REQ_TRY, 8'h5B, 16'd0, 1'b0));
    send_req(make_req(REQ_RELEASE, 8'h5C, 16'(QUEUE_DEPTH), 1'b0));
  endtask

  task automatic random_phase(input logic [15:0] init_v, input logic [15:0] max_v,
                              input int n_items, input int acquire_pct,
                              input bit with_idle);
    cfg_write(CFG_MAX_COUNT, max_v);
    cfg_write(CFG_INITIAL_COUNT, init_v);
    idle_on = with_idle;
    repeat (n_items) send_req(random_request(acquire_pct));
    wait_idle();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    random_phase(16'd0, 16'hFFFF, 100, 50, 1'b1);
    random_phase(16'd1, 16'd3, 80, 40, 1'b1);
    random_phase(16'hFFFF, 16'hFFFF, 60, 35, 1'b0);
    cfg_write(CFG_UNUSED_IDX, 16'($urandom));
    random_phase(16'($urandom), 16'($urandom_range(1, 65535)), 100, 40, 1'b1);
    random_phase(16'd4, 16'd1, 60, 40, 1'b1);
    random_phase(16'd2, 16'd16, 100, 55, 1'b1);
  endtask

  initial begin
    max_reg   = MAX_COUNT_RST;
    sem_avail = INITIAL_COUNT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_config_limits();
    test_queue_full();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
